>>> rtl/core/v3au_pkg.sv
// ---------------------------------------------------------------------------
// v3au_pkg: shared types for the vec3 arithmetic unit
// Word formats, opcodes, pipeline carry records and the saturation helper.
// ---------------------------------------------------------------------------
package v3au_pkg;

   localparam int DATA_W = 32;             // signed fixed-point word
   localparam int SAT_W  = 2 * DATA_W + 2; // widest intermediate before saturation

   typedef logic signed [DATA_W-1:0] word_type;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_NEG    = 3'd2,
      OP_SCALE  = 3'd3,
      OP_DOT    = 3'd4,
      OP_LENGTH = 3'd5,
      OP_NORM   = 3'd6
   } op_type;

   typedef struct packed {
      op_type   opcode;
      word_type a_x;
      word_type a_y;
      word_type a_z;
      word_type b_x;
      word_type b_y;
      word_type b_z;
      word_type scale;
   } req_type;

   typedef struct packed {
      word_type r_x;
      word_type r_y;
      word_type r_z;
      word_type r_scalar;
      logic     overflow;
   } rsp_type;

   typedef struct packed {
      word_type val;
      logic     ovf;
   } sat_type;

   // one lane's registered results
   typedef struct packed {
      sat_type                  add;
      sat_type                  sub;
      sat_type                  neg;
      logic signed [2*DATA_W-1:0] prod_ab;
      logic signed [2*DATA_W-1:0] prod_ac;
      logic [2*DATA_W-1:0]      sq;
   } lane_type;

   // travels down the long pipeline beside each word
   typedef struct packed {
      op_type   opcode;
      word_type a_x;
      word_type a_y;
      word_type a_z;
      rsp_type  rsp;
   } carry_type;

   localparam word_type WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   function automatic sat_type sat_word(input logic signed [SAT_W-1:0] v);
      sat_type r;
      logic    hi_ones;
      logic    hi_zeros;
      hi_ones  = &v[SAT_W-1:DATA_W-1];
      hi_zeros = ~|v[SAT_W-1:DATA_W-1];
      r.ovf    = !(hi_ones || hi_zeros);
      r.val    = r.ovf ? (v[SAT_W-1] ? WORD_MIN : WORD_MAX) : v[DATA_W-1:0];
      return r;
   endfunction

endpackage

>>> rtl/core/v3au_lane.sv
// ---------------------------------------------------------------------------
// v3au_lane: one vector component
// Add, subtract, negate with saturation, plus the raw products a*b, a*c, a*a.
// ---------------------------------------------------------------------------
module v3au_lane (
   input  logic               clock,
   input  v3au_pkg::word_type a,
   input  v3au_pkg::word_type b,
   input  v3au_pkg::word_type c,
   output v3au_pkg::lane_type lane_ff
);
   import v3au_pkg::*;

   lane_type lane_in;

   always_comb begin
      lane_in.add     = sat_word(SAT_W'(a) + SAT_W'(b));
      lane_in.sub     = sat_word(SAT_W'(a) - SAT_W'(b));
      lane_in.neg     = sat_word(-SAT_W'(a));
      lane_in.prod_ab = (2*DATA_W)'(a) * (2*DATA_W)'(b);
      lane_in.prod_ac = (2*DATA_W)'(a) * (2*DATA_W)'(c);
      lane_in.sq      = (2*DATA_W)'(a) * (2*DATA_W)'(a);
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

endmodule

>>> rtl/core/v3au_merge.sv
// ---------------------------------------------------------------------------
// v3au_merge: combines the three lanes
// Picks the result of the direct ops, sums the dot product and the squares.
// ---------------------------------------------------------------------------
module v3au_merge #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid,
   input  v3au_pkg::carry_type    carry,
   input  v3au_pkg::lane_type     lane [3],
   output logic                   valid_ff,
   output v3au_pkg::carry_type    carry_ff,
   output logic [2*v3au_pkg::DATA_W-1:0] rad_ff
);
   import v3au_pkg::*;

   carry_type              carry_in;
   logic [2*DATA_W-1:0]    rad_in;
   sat_type                scl [3];
   sat_type                dot;
   logic signed [SAT_W-1:0] dot_sum;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         scl[i] = sat_word(SAT_W'($signed(lane[i].prod_ac)) >>> FRAC_BITS);
      end
      dot_sum = SAT_W'($signed(lane[0].prod_ab)) + SAT_W'($signed(lane[1].prod_ab))
              + SAT_W'($signed(lane[2].prod_ab));
      dot     = sat_word(dot_sum >>> FRAC_BITS);
      rad_in  = lane[0].sq + lane[1].sq + lane[2].sq;

      carry_in     = carry;
      carry_in.rsp = '0;
      unique case (carry.opcode)
         OP_ADD: begin
            carry_in.rsp = '{lane[0].add.val, lane[1].add.val, lane[2].add.val, '0,
                             lane[0].add.ovf | lane[1].add.ovf | lane[2].add.ovf};
         end
         OP_SUB: begin
            carry_in.rsp = '{lane[0].sub.val, lane[1].sub.val, lane[2].sub.val, '0,
                             lane[0].sub.ovf | lane[1].sub.ovf | lane[2].sub.ovf};
         end
         OP_NEG: begin
            carry_in.rsp = '{lane[0].neg.val, lane[1].neg.val, lane[2].neg.val, '0,
                             lane[0].neg.ovf | lane[1].neg.ovf | lane[2].neg.ovf};
         end
         OP_SCALE: begin
            carry_in.rsp = '{scl[0].val, scl[1].val, scl[2].val, '0,
                             scl[0].ovf | scl[1].ovf | scl[2].ovf};
         end
         OP_DOT: begin
            carry_in.rsp = '{'0, '0, '0, dot.val, dot.ovf};
         end
         default: begin
            carry_in.rsp = '0;  // length, normalize filled later; code 7 stays zero
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid;
      end
      carry_ff <= carry_in;
      rad_ff   <= rad_in;
   end

endmodule

>>> rtl/core/v3au_sqrt.sv
// ---------------------------------------------------------------------------
// v3au_sqrt: pipelined integer square root
// One root bit per stage, restoring remainder method, DATA_W stages.
// ---------------------------------------------------------------------------
module v3au_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid,
   input  logic [2*v3au_pkg::DATA_W-1:0] rad,
   input  v3au_pkg::carry_type           carry,
   output logic                          valid_out,
   output logic [v3au_pkg::DATA_W-1:0]   root_out,
   output v3au_pkg::carry_type           carry_out
);
   import v3au_pkg::*;

   logic [DATA_W+1:0]   rem_ff   [DATA_W];
   logic [DATA_W-1:0]   root_ff  [DATA_W];
   logic [2*DATA_W-1:0] rad_ff   [DATA_W];
   carry_type           carry_ff [DATA_W];
   logic                vld_ff   [DATA_W];

   for (genvar k = 0; k < DATA_W; k++) begin : g_stage
      logic [DATA_W+1:0]   rem_p;
      logic [DATA_W-1:0]   root_p;
      logic [2*DATA_W-1:0] rad_p;
      carry_type           carry_p;
      logic                vld_p;
      logic [DATA_W+1:0]   shifted;
      logic [DATA_W+1:0]   trial;
      logic [DATA_W+1:0]   rem_in;
      logic [DATA_W-1:0]   root_in;

      if (k == 0) begin : g_first
         assign rem_p   = '0;
         assign root_p  = '0;
         assign rad_p   = rad;
         assign carry_p = carry;
         assign vld_p   = valid;
      end else begin : g_next
         assign rem_p   = rem_ff[k-1];
         assign root_p  = root_ff[k-1];
         assign rad_p   = rad_ff[k-1];
         assign carry_p = carry_ff[k-1];
         assign vld_p   = vld_ff[k-1];
      end

      // remainder stays below 2^DATA_W, so its top two bits drop safely
      always_comb begin
         shifted = {rem_p[DATA_W-1:0], rad_p[2*DATA_W-1 -: 2]};
         trial   = {root_p, 2'b01};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_p[DATA_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_p[DATA_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_p;
         end
         rem_ff[k]   <= rem_in;
         root_ff[k]  <= root_in;
         rad_ff[k]   <= rad_p << 2;
         carry_ff[k] <= carry_p;
      end
   end

   assign valid_out = vld_ff[DATA_W-1];
   assign root_out  = root_ff[DATA_W-1];
   assign carry_out = carry_ff[DATA_W-1];

endmodule

>>> rtl/core/v3au_recip.sv
// ---------------------------------------------------------------------------
// v3au_recip: pipelined reciprocal 2^(2*FRAC_BITS) / len
// Restoring long division, one quotient bit per stage.
// ---------------------------------------------------------------------------
module v3au_recip #(
   parameter int FRAC_BITS = 16,
   parameter int QB        = 2 * FRAC_BITS + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        valid,
   input  logic [v3au_pkg::DATA_W-1:0] len,
   input  v3au_pkg::carry_type         carry,
   output logic                        valid_out,
   output logic [QB-1:0]               q_out,
   output v3au_pkg::carry_type         carry_out
);
   import v3au_pkg::*;

   localparam int CW = QB + DATA_W + 1;

   logic [DATA_W-1:0] rem_ff   [QB];
   logic [QB-1:0]     q_ff     [QB];
   logic [DATA_W-1:0] d_ff     [QB];
   carry_type         carry_ff [QB];
   logic              vld_ff   [QB];

   for (genvar j = 0; j < QB; j++) begin : g_stage
      logic [DATA_W-1:0] rem_p;
      logic [QB-1:0]     q_p;
      logic [DATA_W-1:0] d_p;
      carry_type         carry_p;
      logic              vld_p;
      logic [DATA_W:0]   shifted;
      logic [DATA_W-1:0] rem_in;
      logic [QB-1:0]     q_in;

      if (j == 0) begin : g_first
         assign rem_p   = '0;
         assign q_p     = '0;
         assign d_p     = (len == '0) ? DATA_W'(1) : len;
         assign carry_p = carry;
         assign vld_p   = valid;
      end else begin : g_next
         assign rem_p   = rem_ff[j-1];
         assign q_p     = q_ff[j-1];
         assign d_p     = d_ff[j-1];
         assign carry_p = carry_ff[j-1];
         assign vld_p   = vld_ff[j-1];
      end

      // numerator is a single one in its top bit
      always_comb begin
         shifted = {rem_p, (j == 0) ? 1'b1 : 1'b0};
         if (shifted >= {1'b0, d_p}) begin
            rem_in = DATA_W'(shifted - {1'b0, d_p});
            q_in   = {q_p[QB-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            q_in   = {q_p[QB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_p;
         end
         rem_ff[j]   <= rem_in;
         q_ff[j]     <= q_in;
         d_ff[j]     <= d_p;
         carry_ff[j] <= carry_p;
      end
   end

   assign valid_out = vld_ff[QB-1];
   assign q_out     = q_ff[QB-1];
   assign carry_out = carry_ff[QB-1];

   logic [CW-1:0] qd_lo;
   logic [CW-1:0] qd_hi;
   logic [CW-1:0] num;

   assign qd_lo = CW'(q_out) * CW'(d_ff[QB-1]);
   assign qd_hi = qd_lo + CW'(d_ff[QB-1]);
   assign num   = CW'(1) << (2 * FRAC_BITS);

   a_q_not_high: assert property (@(posedge clock) disable iff (reset)
      valid_out |-> qd_lo <= num)
      else $error("reciprocal quotient too large");

   a_q_not_low: assert property (@(posedge clock) disable iff (reset)
      valid_out |-> qd_hi > num)
      else $error("reciprocal quotient too small");

endmodule

>>> rtl/core/vec3_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// vec3_arithmetic_unit: three-component fixed-point vector ALU
// add, sub, negate, scale, dot, length, normalize on signed Q16.16 words.
// ---------------------------------------------------------------------------
//
//  channel   ports                      direction  handshake
//  request   start, busy, req_data      in         start && !busy
//  response  rsp_valid, rsp_data        out        rsp_valid, one cycle
//
//  One word enters per cycle; busy is always low, the datapath is a
//  fixed pipeline with no stalls. The square root (one bit per stage) is
//  followed by the reciprocal divider (one quotient bit per stage).
//  Every opcode passes the whole pipeline, so results leave in order.
//  Synchronous reset clears only the valid bits of the pipeline.
//  The receiver cannot stall: each result is shown for a single cycle.
//
module vec3_arithmetic_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  v3au_pkg::req_type req_data,
   output logic              rsp_valid,
   output v3au_pkg::rsp_type rsp_data
);
   import v3au_pkg::*;

   localparam int QB      = 2 * FRAC_BITS + 1;   // reciprocal bits
   localparam int PW      = DATA_W + QB + 1;     // normalize product
   localparam int LATENCY = DATA_W + QB + 4;     // accept edge to sampled strobe

   logic accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // stage 1: three lanes, one per component
   word_type av [3];
   word_type bv [3];
   lane_type lane [3];

   assign av[0] = req_data.a_x;
   assign av[1] = req_data.a_y;
   assign av[2] = req_data.a_z;
   assign bv[0] = req_data.b_x;
   assign bv[1] = req_data.b_y;
   assign bv[2] = req_data.b_z;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      v3au_lane u_lane (
         .clock   (clock),
         .a       (av[i]),
         .b       (bv[i]),
         .c       (req_data.scale),
         .lane_ff (lane[i])
      );
   end

   logic      s1_vld_ff;
   carry_type s1_carry_ff;
   carry_type s1_carry_in;

   always_comb begin
      s1_carry_in        = '0;
      s1_carry_in.opcode = req_data.opcode;
      s1_carry_in.a_x    = req_data.a_x;
      s1_carry_in.a_y    = req_data.a_y;
      s1_carry_in.a_z    = req_data.a_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
      s1_carry_ff <= s1_carry_in;
   end

   // stage 2: merge lanes, direct results settle here
   logic                s2_vld;
   carry_type           s2_carry;
   logic [2*DATA_W-1:0] s2_rad;

   v3au_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock    (clock),
      .reset    (reset),
      .valid    (s1_vld_ff),
      .carry    (s1_carry_ff),
      .lane     (lane),
      .valid_ff (s2_vld),
      .carry_ff (s2_carry),
      .rad_ff   (s2_rad)
   );

   // square root of the sum of squares
   logic              sq_vld;
   logic [DATA_W-1:0] sq_root;
   carry_type         sq_carry;

   v3au_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .valid     (s2_vld),
      .rad       (s2_rad),
      .carry     (s2_carry),
      .valid_out (sq_vld),
      .root_out  (sq_root),
      .carry_out (sq_carry)
   );

   // length result drops in here; the divider just carries it along
   carry_type rc_carry_in;
   sat_type   len_sat;

   always_comb begin
      len_sat     = sat_word(SAT_W'({1'b0, sq_root}));
      rc_carry_in = sq_carry;
      if (sq_carry.opcode == OP_LENGTH) begin
         rc_carry_in.rsp.r_scalar = len_sat.val;
         rc_carry_in.rsp.overflow = len_sat.ovf;
      end
   end

   logic          rc_vld;
   logic [QB-1:0] rc_q;
   carry_type     rc_carry;

   v3au_recip #(.FRAC_BITS(FRAC_BITS), .QB(QB)) u_recip (
      .clock     (clock),
      .reset     (reset),
      .valid     (sq_vld),
      .len       (sq_root),
      .carry     (rc_carry_in),
      .valid_out (rc_vld),
      .q_out     (rc_q),
      .carry_out (rc_carry)
   );

   // normalize: A times the reciprocal
   logic signed [PW-1:0] nm_prod_ff [3];
   logic                 nm_vld_ff;
   carry_type            nm_carry_ff;
   word_type             rc_a [3];

   assign rc_a[0] = rc_carry.a_x;
   assign rc_a[1] = rc_carry.a_y;
   assign rc_a[2] = rc_carry.a_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_vld_ff <= 1'b0;
      end else begin
         nm_vld_ff <= rc_vld;
      end
      nm_carry_ff <= rc_carry;
      for (int i = 0; i < 3; i++) begin
         nm_prod_ff[i] <= PW'(rc_a[i]) * $signed(PW'({1'b0, rc_q}));
      end
   end

   // final shift and saturate
   rsp_type rsp_in;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;
   sat_type nm_sat [3];
   logic    a_zero;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nm_sat[i] = sat_word(SAT_W'(nm_prod_ff[i] >>> FRAC_BITS));
      end
      a_zero = (nm_carry_ff.a_x == '0) && (nm_carry_ff.a_y == '0)
            && (nm_carry_ff.a_z == '0);
      rsp_in = nm_carry_ff.rsp;
      if (nm_carry_ff.opcode == OP_NORM) begin
         if (a_zero) begin
            rsp_in = '0;
         end else begin
            rsp_in = '{nm_sat[0].val, nm_sat[1].val, nm_sat[2].val, '0,
                       nm_sat[0].ovf | nm_sat[1].ovf | nm_sat[2].ovf};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= nm_vld_ff;
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without matching request");

   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |->
         rsp_data.r_x == WORD_MAX || rsp_data.r_x == WORD_MIN ||
         rsp_data.r_y == WORD_MAX || rsp_data.r_y == WORD_MIN ||
         rsp_data.r_z == WORD_MAX || rsp_data.r_z == WORD_MIN ||
         rsp_data.r_scalar == WORD_MAX || rsp_data.r_scalar == WORD_MIN)
      else $error("overflow flagged without a saturated field");

   a_scalar_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.r_scalar != '0 |->
         rsp_data.r_x == '0 && rsp_data.r_y == '0 && rsp_data.r_z == '0)
      else $error("scalar and vector result both nonzero");

endmodule
